// ===== rtl/aicp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_pkg
// Shared types and constants for the animated image container parser.
// ----------------------------------------------------------------------------
package aicp_pkg;

  localparam int LENGTH_FIELD_BYTES = 8;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [7:0]  CH_C      = 8'h43;
  localparam logic [7:0]  CH_A      = 8'h41;
  localparam logic [7:0]  CH_F      = 8'h46;
  localparam logic [7:0]  CH_I      = 8'h49;
  localparam logic [7:0]  CH_SEMI   = 8'h3B;
  localparam logic [7:0]  CH_NL     = 8'h0A;
  localparam logic [7:0]  ID_HDR    = 8'd1;
  localparam logic [7:0]  ID_CRED   = 8'd2;
  localparam logic [7:0]  ID_ANIM   = 8'd3;
  localparam logic [31:0] MAGIC_HDR = {CH_F, CH_F, CH_A, CH_C};
  localparam logic [31:0] MAGIC_IMG = {CH_F, CH_F, CH_I, CH_C};

  typedef enum logic [3:0] {
    KIND_ANIM_COUNT  = 4'd0,
    KIND_DATE        = 4'd1,
    KIND_CREATOR     = 4'd2,
    KIND_DURATION    = 4'd3,
    KIND_CONTENT     = 4'd4,
    KIND_WIDTH       = 4'd5,
    KIND_HEIGHT      = 4'd6,
    KIND_CAPTION     = 4'd7,
    KIND_TAG         = 4'd8,
    KIND_PIXEL       = 4'd9,
    KIND_DONE        = 4'd10,
    KIND_BAD_MAGIC   = 4'd11,
    KIND_TRUNCATED   = 4'd12,
    KIND_BAD_TAG_LEN = 4'd13
  } kind_t;

  typedef enum logic [21:0] {
    PH_ID        = 22'h000001,
    PH_LEN_HDR   = 22'h000002,
    PH_LEN_CRED  = 22'h000004,
    PH_LEN_ANIM  = 22'h000008,
    PH_LEN_OTHER = 22'h000010,
    PH_SKIP      = 22'h000020,
    PH_H_MAGIC   = 22'h000040,
    PH_H_SIZE    = 22'h000080,
    PH_H_COUNT   = 22'h000100,
    PH_C_DATE    = 22'h000200,
    PH_C_LEN     = 22'h000400,
    PH_C_CHARS   = 22'h000800,
    PH_A_DUR     = 22'h001000,
    PH_I_MAGIC   = 22'h002000,
    PH_I_HSIZE   = 22'h004000,
    PH_I_CSIZE   = 22'h008000,
    PH_I_WIDTH   = 22'h010000,
    PH_I_HEIGHT  = 22'h020000,
    PH_I_CAPTION = 22'h040000,
    PH_I_TAGS    = 22'h080000,
    PH_I_PIXELS  = 22'h100000,
    PH_ERROR     = 22'h200000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic [15:0] image_number;
    logic        last;
  } result_t;

  // up to two results caused by one byte, in order
  typedef struct packed {
    logic    v0;
    result_t r0;
    logic    v1;
    result_t r1;
  } entry_t;

endpackage

// ===== rtl/aicp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_in_if / aicp_out_if
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface aicp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface aicp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  item_kind;
  logic [63:0] item_value;
  logic [15:0] image_number;
  logic        last_of_file;
  modport source (output valid, output item_kind, output item_value, output image_number,
                  output last_of_file, input ready);
  modport sink (input valid, input item_kind, input item_value, input image_number,
                input last_of_file, output ready);
endinterface

// ===== rtl/aicp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_front
// Byte parser: walks the block structure one byte per cycle while the queue
// is not full and hands the results each byte causes to the queue.
// ----------------------------------------------------------------------------
module aicp_front (
  input  logic              clk,
  input  logic              rst_n,
  aicp_in_if.sink           in_ch,
  input  logic              queue_full,
  output logic              push,
  output aicp_pkg::entry_t  push_entry
);

  aicp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] hsize_r, hsize_nxt;
  logic [63:0] cons_r, cons_nxt;
  logic [63:0] width_r, width_nxt;
  logic [63:0] height_r, height_nxt;
  logic [63:0] col_r, col_nxt;
  logic [63:0] row_r, row_nxt;
  logic [15:0] pp_r, pp_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic [15:0] img_r, img_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [63:0] acc_take;
  logic [3:0]  cnt_inc;
  logic [3:0]  len_sel;
  logic        take_done;
  logic        is_take;
  logic [63:0] cons_inc;
  logic [63:0] col_inc;
  logic [63:0] row_inc;
  logic [63:0] tag_rem;
  logic        do_start;
  logic        do_finish;
  aicp_pkg::entry_t e;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && !queue_full;
  assign b           = in_ch.data_byte;
  assign acc_take    = acc_r | ({56'd0, b} << {cnt_r[2:0], 3'b000});
  assign cnt_inc     = cnt_r + 4'd1;
  assign take_done   = cnt_inc >= len_sel;
  assign col_inc     = col_r + 64'd1;
  assign row_inc     = row_r + 64'd1;

  always_comb begin
    case (phase_r)
      aicp_pkg::PH_LEN_HDR, aicp_pkg::PH_LEN_CRED, aicp_pkg::PH_LEN_ANIM,
      aicp_pkg::PH_LEN_OTHER: len_sel = 4'(aicp_pkg::LENGTH_FIELD_BYTES);
      aicp_pkg::PH_H_MAGIC, aicp_pkg::PH_I_MAGIC: len_sel = 4'd4;
      aicp_pkg::PH_C_DATE: len_sel = 4'd6;
      default: len_sel = 4'd8;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    rem_nxt    = rem_r;
    hsize_nxt  = hsize_r;
    cons_nxt   = cons_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pp_nxt     = pp_r;
    chan_nxt   = chan_r;
    img_nxt    = img_r;
    do_start   = 1'b0;
    do_finish  = 1'b0;
    is_take    = 1'b0;
    e          = '0;
    e.r0.image_number = img_r;
    e.r0.kind  = aicp_pkg::KIND_DONE;
    e.r1.kind  = aicp_pkg::KIND_DONE;

    case (phase_r)
      aicp_pkg::PH_I_MAGIC, aicp_pkg::PH_I_HSIZE, aicp_pkg::PH_I_CSIZE,
      aicp_pkg::PH_I_WIDTH, aicp_pkg::PH_I_HEIGHT,
      aicp_pkg::PH_I_CAPTION: cons_inc = cons_r + 64'd1;
      default: cons_inc = cons_r;
    endcase
    cons_nxt = cons_inc;
    tag_rem  = hsize_r - cons_inc;

    case (phase_r)
      aicp_pkg::PH_ID: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (b == aicp_pkg::ID_HDR) phase_nxt = aicp_pkg::PH_LEN_HDR;
        else if (b == aicp_pkg::ID_CRED) phase_nxt = aicp_pkg::PH_LEN_CRED;
        else if (b == aicp_pkg::ID_ANIM) phase_nxt = aicp_pkg::PH_LEN_ANIM;
        else phase_nxt = aicp_pkg::PH_LEN_OTHER;
      end
      aicp_pkg::PH_LEN_HDR: begin
        is_take = 1'b1;
        if (take_done) phase_nxt = aicp_pkg::PH_H_MAGIC;
      end
      aicp_pkg::PH_LEN_CRED: begin
        is_take = 1'b1;
        if (take_done) phase_nxt = aicp_pkg::PH_C_DATE;
      end
      aicp_pkg::PH_LEN_ANIM: begin
        is_take = 1'b1;
        if (take_done) phase_nxt = aicp_pkg::PH_A_DUR;
      end
      aicp_pkg::PH_LEN_OTHER: begin
        is_take = 1'b1;
        if (take_done) begin
          rem_nxt   = acc_take;
          phase_nxt = (acc_take == 64'd0) ? aicp_pkg::PH_ID : aicp_pkg::PH_SKIP;
        end
      end
      aicp_pkg::PH_SKIP: begin
        rem_nxt = rem_r - 64'd1;
        if (rem_r == 64'd1) phase_nxt = aicp_pkg::PH_ID;
      end
      aicp_pkg::PH_H_MAGIC, aicp_pkg::PH_I_MAGIC: begin
        is_take = 1'b1;
        if (take_done) begin
          if (acc_take[31:0] != ((phase_r == aicp_pkg::PH_H_MAGIC) ?
              aicp_pkg::MAGIC_HDR : aicp_pkg::MAGIC_IMG) || acc_take[63:32] != 32'd0) begin
            e.v0      = 1'b1;
            e.r0.kind = aicp_pkg::KIND_BAD_MAGIC;
            e.r0.last = 1'b1;
            phase_nxt = aicp_pkg::PH_ERROR;
          end else begin
            phase_nxt = (phase_r == aicp_pkg::PH_H_MAGIC) ? aicp_pkg::PH_H_SIZE
                                                         : aicp_pkg::PH_I_HSIZE;
          end
        end
      end
      aicp_pkg::PH_H_SIZE: begin
        is_take = 1'b1;
        if (take_done) phase_nxt = aicp_pkg::PH_H_COUNT;
      end
      aicp_pkg::PH_H_COUNT: begin
        is_take = 1'b1;
        if (take_done) begin
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_ANIM_COUNT; e.r0.value = acc_take;
          phase_nxt = aicp_pkg::PH_ID;
        end
      end
      aicp_pkg::PH_C_DATE: begin
        is_take = 1'b1;
        if (take_done) begin
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_DATE; e.r0.value = acc_take;
          phase_nxt = aicp_pkg::PH_C_LEN;
        end
      end
      aicp_pkg::PH_C_LEN: begin
        is_take = 1'b1;
        if (take_done) begin
          rem_nxt   = acc_take;
          phase_nxt = (acc_take == 64'd0) ? aicp_pkg::PH_ID : aicp_pkg::PH_C_CHARS;
        end
      end
      aicp_pkg::PH_C_CHARS: begin
        e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_CREATOR; e.r0.value = {56'd0, b};
        rem_nxt = rem_r - 64'd1;
        if (rem_r == 64'd1) phase_nxt = aicp_pkg::PH_ID;
      end
      aicp_pkg::PH_A_DUR: begin
        is_take = 1'b1;
        if (take_done) begin
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_DURATION; e.r0.value = acc_take;
          cons_nxt  = '0;
          phase_nxt = aicp_pkg::PH_I_MAGIC;
        end
      end
      aicp_pkg::PH_I_HSIZE: begin
        is_take = 1'b1;
        if (take_done) begin
          hsize_nxt = acc_take;
          phase_nxt = aicp_pkg::PH_I_CSIZE;
        end
      end
      aicp_pkg::PH_I_CSIZE: begin
        is_take = 1'b1;
        if (take_done) begin
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_CONTENT; e.r0.value = acc_take;
          phase_nxt = aicp_pkg::PH_I_WIDTH;
        end
      end
      aicp_pkg::PH_I_WIDTH: begin
        is_take = 1'b1;
        if (take_done) begin
          width_nxt = acc_take;
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_WIDTH; e.r0.value = acc_take;
          phase_nxt = aicp_pkg::PH_I_HEIGHT;
        end
      end
      aicp_pkg::PH_I_HEIGHT: begin
        is_take = 1'b1;
        if (take_done) begin
          height_nxt = acc_take;
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_HEIGHT; e.r0.value = acc_take;
          phase_nxt = aicp_pkg::PH_I_CAPTION;
        end
      end
      aicp_pkg::PH_I_CAPTION: begin
        if (b != aicp_pkg::CH_NL) begin
          e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_CAPTION; e.r0.value = {56'd0, b};
        end else if (hsize_r < cons_inc) begin
          e.v0      = 1'b1;
          e.r0.kind = aicp_pkg::KIND_BAD_TAG_LEN;
          e.r0.last = 1'b1;
          phase_nxt = aicp_pkg::PH_ERROR;
        end else begin
          rem_nxt = tag_rem;
          if (tag_rem == 64'd0) do_start = 1'b1;
          else phase_nxt = aicp_pkg::PH_I_TAGS;
        end
      end
      aicp_pkg::PH_I_TAGS: begin
        e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_TAG;
        e.r0.value = {56'd0, (b == 8'd0) ? aicp_pkg::CH_SEMI : b};
        rem_nxt = rem_r - 64'd1;
        if (rem_r == 64'd1) do_start = 1'b1;
      end
      aicp_pkg::PH_I_PIXELS: begin
        case (chan_r)
          2'd0: begin
            pp_nxt   = {8'd0, b};
            chan_nxt = 2'd1;
          end
          2'd1: begin
            pp_nxt   = {b, pp_r[7:0]};
            chan_nxt = 2'd2;
          end
          default: begin
            e.v0 = 1'b1; e.r0.kind = aicp_pkg::KIND_PIXEL;
            e.r0.value = {40'd0, b, pp_r};
            chan_nxt = 2'd0;
            pp_nxt   = '0;
            if (col_inc >= height_r) begin
              col_nxt = '0;
              row_nxt = row_inc;
              if (row_inc >= width_r) do_finish = 1'b1;
            end else begin
              col_nxt = col_inc;
            end
          end
        endcase
      end
      aicp_pkg::PH_ERROR: phase_nxt = aicp_pkg::PH_ERROR;
      default: phase_nxt = aicp_pkg::PH_ERROR;
    endcase

    if (is_take) begin
      if (take_done) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end else begin
        acc_nxt = acc_take;
        cnt_nxt = cnt_inc;
      end
    end

    if (do_start) begin
      col_nxt  = '0;
      row_nxt  = '0;
      chan_nxt = '0;
      pp_nxt   = '0;
      if (width_r == 64'd0 || height_r == 64'd0) do_finish = 1'b1;
      else phase_nxt = aicp_pkg::PH_I_PIXELS;
    end

    if (do_finish) begin
      if (img_r != 16'hFFFF) img_nxt = img_r + 16'd1;
      phase_nxt = aicp_pkg::PH_ID;
    end

    if (in_ch.end_of_file) begin
      e.r1.image_number = img_nxt;
      e.r1.last         = 1'b1;
      if (phase_nxt == aicp_pkg::PH_ID) begin
        e.v1 = 1'b1; e.r1.kind = aicp_pkg::KIND_DONE;
      end else if (phase_nxt != aicp_pkg::PH_ERROR) begin
        e.v1 = 1'b1; e.r1.kind = aicp_pkg::KIND_TRUNCATED;
      end
      phase_nxt  = aicp_pkg::PH_ID;
      cnt_nxt    = '0;
      acc_nxt    = '0;
      rem_nxt    = '0;
      hsize_nxt  = '0;
      cons_nxt   = '0;
      width_nxt  = '0;
      height_nxt = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      pp_nxt     = '0;
      chan_nxt   = '0;
      img_nxt    = '0;
    end
  end

  assign push       = accept && (e.v0 || e.v1);
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= aicp_pkg::PH_ID;
      cnt_r    <= '0;
      acc_r    <= '0;
      rem_r    <= '0;
      hsize_r  <= '0;
      cons_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      pp_r     <= '0;
      chan_r   <= '0;
      img_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      rem_r    <= rem_nxt;
      hsize_r  <= hsize_nxt;
      cons_r   <= cons_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pp_r     <= pp_nxt;
      chan_r   <= chan_nxt;
      img_r    <= img_nxt;
    end
  end

endmodule

// ===== rtl/aicp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_queue
// Short FIFO of result groups between the parser and the output stage.
// ----------------------------------------------------------------------------
module aicp_queue #(
  parameter int DEPTH = aicp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aicp_pkg::entry_t push_entry,
  input  logic             pop,
  output aicp_pkg::entry_t head,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  aicp_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/aicp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aicp_back
// Output stage: unpacks each result group into single words behind an
// output register.
// ----------------------------------------------------------------------------
module aicp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  aicp_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  aicp_out_if.source       out_ch
);

  logic             out_valid_r, out_valid_nxt;
  aicp_pkg::result_t out_r, out_nxt;
  logic             sel_r, sel_nxt;
  logic             load_ok;
  logic             use_first;
  logic             is_last;

  assign load_ok   = !out_valid_r || out_ch.ready;
  assign use_first = !sel_r && head.v0;
  assign is_last   = !use_first || !head.v1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    sel_nxt       = sel_r;
    pop           = 1'b0;
    if (load_ok) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_nxt = use_first ? head.r0 : head.r1;
        if (is_last) begin
          pop     = 1'b1;
          sel_nxt = 1'b0;
        end else begin
          sel_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.item_kind    = out_r.kind;
  assign out_ch.item_value   = out_r.value;
  assign out_ch.image_number = out_r.image_number;
  assign out_ch.last_of_file = out_r.last;

endmodule

// ===== rtl/animated_image_container_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animated_image_container_parser_core
// Streaming parser for an animated image container, one byte per word.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and returns the decoded fields, characters
// and pixels as result words, plus a done or truncated word at end of file
// and an error word on a bad magic or tag length. The parser decodes each
// byte as it is accepted; its results go through a small queue to an output
// register that sends one result per cycle while the output is ready, so a
// byte that yields two results (a final field and the end-of-file word)
// sends them in turn. Input stalls only when the queue is full.
module animated_image_container_parser_core #(
  parameter int QUEUE_DEPTH = aicp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  aicp_in_if.sink     in_ch,
  aicp_out_if.source  out_ch
);

  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  aicp_pkg::entry_t push_entry;
  aicp_pkg::entry_t head;

  aicp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  aicp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  aicp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
